// ===== sv/ps2_mouse_packet_cursor_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PS2MCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2mct assertion failed");
// next-cycle implication
`define PS2MCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2mct assertion failed");
`else
`define PS2MCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PS2MCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ps2mct_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Types, constants and arithmetic helpers of the PS/2 cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    // header byte bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 16;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 16'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 16'd768;
    localparam logic [7:0]        OVF_EXTRA    = 8'd255;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_X   = 2'd1,
        PH_Y   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
    } t_pkt;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // signed movement of one axis: magnitude, plus overflow, then sign
    function automatic logic signed [17:0] axis_delta(input logic [7:0] b,
                                                      input logic       neg,
                                                      input logic       ovf);
        logic [7:0] mag8;
        logic [9:0] mag;
        mag8 = neg ? (8'd0 - b) : b;
        mag  = {2'b00, mag8} + (ovf ? {2'b00, OVF_EXTRA} : 10'd0);
        axis_delta = neg ? -$signed({8'b0, mag}) : $signed({8'b0, mag});
    endfunction

    // clamp to 1 first, then to size-1 (size zero gives limit zero)
    function automatic logic [SIZE_W-1:0] axis_clamp(input logic signed [17:0] v,
                                                     input logic [SIZE_W-1:0] size);
        logic signed [17:0] limit;
        logic signed [17:0] w;
        limit = (size == '0) ? 18'sd0 : $signed({2'b00, size} - 18'd1);
        w     = (v <= 18'sd1) ? 18'sd1 : v;
        if (w >= limit) begin
            w = limit;
        end
        axis_clamp = w[SIZE_W-1:0];
    endfunction

endpackage

// ===== sv/ps2_mouse_packet_cursor_tracker_core.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// Frames PS/2 mouse bytes into packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Input channel: one raw mouse byte per word (i_in_valid / o_in_stall).
// A header byte without bit 3 is dropped. Every third byte of a framed
// packet yields one result word on the output channel (o_out_valid /
// i_out_stall): cursor x, cursor y (downward positive) and three buttons.
// The packet enters the queue at the edge that accepts its last byte; the
// back stage pops it into the result register. Throughput: one byte per
// cycle while the queue is not full; the cursor update is a single add and
// clamp per axis in the back stage.
// A two-entry packet queue parts framing from the update; the input stalls
// only when the queue is full, which happens only after the receiver has
// held i_out_stall long enough. A stalled result holds its value.
// Reset: phase awaits a header, cursor at 0,0, screen 1024 x 768.
// Registers over the APB port: width at 0x0, height at 0x4, low 16 bits.
// Clamp range per axis is 1 .. size-1. Write registers only while idle.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_core_defines.svh"

module ps2_mouse_packet_cursor_tracker_core
    import ps2mct_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [SIZE_W-1:0] o_cursor_x,
    output logic [SIZE_W-1:0] o_cursor_y,
    output logic              o_left_pressed,
    output logic              o_middle_pressed,
    output logic              o_right_pressed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              w_cfg_wr;
    t_reg_idx          w_reg;
    logic              w_accept;
    logic              w_push;
    logic              w_pop;
    t_pkt              w_push_pkt;
    t_pkt              w_head_pkt;
    t_q_status         w_q_stat;

    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_WIDTH:  prdata = {{(DATA_W-SIZE_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(DATA_W-SIZE_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    assign o_in_stall = w_q_stat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    ps2mct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .o_push      (w_push),
        .o_pkt       (w_push_pkt)
    );

    ps2mct_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pkt    (w_push_pkt),
        .i_pop    (w_pop),
        .o_pkt    (w_head_pkt),
        .o_status (w_q_stat)
    );

    ps2mct_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (w_head_pkt),
        .i_q_status (w_q_stat),
        .o_pop      (w_pop),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_cursor_x (o_cursor_x),
        .o_cursor_y (o_cursor_y),
        .o_left     (o_left_pressed),
        .o_middle   (o_middle_pressed),
        .o_right    (o_right_pressed)
    );

    `PS2MCT_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push, !w_q_stat.empty)
    `PS2MCT_ASSERT_NOW(a_result_from_queue, i_clk, i_rst_n, $rose(o_out_valid), $past(!w_q_stat.empty))
    `PS2MCT_ASSERT_NOW(a_x_on_screen, i_clk, i_rst_n, o_out_valid && (r_width >= 16'd2), (o_cursor_x >= 16'd1) && (o_cursor_x < r_width))

endmodule

// ===== sv/ps2mct_front.sv =====
// ----------------------------------------------------------------------------
// ps2mct_front
// Frames incoming mouse bytes into three-byte packets and queues each packet.
// ----------------------------------------------------------------------------
module ps2mct_front
    import ps2mct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output logic       o_push,
    output t_pkt       o_pkt
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_xb, n_xb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_hdr   <= '0;
            r_xb    <= '0;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_xb    <= n_xb;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_xb    = r_xb;
        o_push  = 1'b0;
        o_pkt   = '{hdr: r_hdr, xb: r_xb, yb: i_data_byte};
        if (i_accept) begin
            case (r_phase)
                PH_X: begin
                    n_xb    = i_data_byte;
                    n_phase = PH_Y;
                end
                PH_Y: begin
                    o_push  = 1'b1;
                    n_phase = PH_HDR;
                end
                default: begin
                    // drop a header without the sync bit
                    if (i_data_byte[HDR_SYNC]) begin
                        n_hdr   = i_data_byte;
                        n_phase = PH_X;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
            endcase
        end
    end

endmodule

// ===== sv/ps2mct_fifo.sv =====
// ----------------------------------------------------------------------------
// ps2mct_fifo
// Short packet queue between the framing front and the cursor update back.
// ----------------------------------------------------------------------------
module ps2mct_fifo
    import ps2mct_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pkt      i_pkt,
    input  logic      i_pop,
    output t_pkt      o_pkt,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    assign o_pkt          = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

endmodule

// ===== sv/ps2mct_back.sv =====
// ----------------------------------------------------------------------------
// ps2mct_back
// Applies queued packets to the cursor position and holds the result word.
// ----------------------------------------------------------------------------
module ps2mct_back
    import ps2mct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pkt              i_pkt,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic [SIZE_W-1:0] i_width,
    input  logic [SIZE_W-1:0] i_height,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SIZE_W-1:0] o_cursor_x,
    output logic [SIZE_W-1:0] o_cursor_y,
    output logic              o_left,
    output logic              o_middle,
    output logic              o_right
);

    logic [SIZE_W-1:0] r_pos_x, n_pos_x;
    logic [SIZE_W-1:0] r_pos_y, n_pos_y;
    logic              r_valid;
    logic [SIZE_W-1:0] r_cx, r_cy;
    logic              r_left, r_middle, r_right;
    logic signed [17:0] w_dx, w_dy;

    // take a packet when the result slot is free or being taken
    assign o_pop = !i_q_status.empty && (!r_valid || !i_stall);

    always_comb begin
        w_dx    = axis_delta(i_pkt.xb, i_pkt.hdr[HDR_XSIGN], i_pkt.hdr[HDR_XOVF]);
        w_dy    = axis_delta(i_pkt.yb, i_pkt.hdr[HDR_YSIGN], i_pkt.hdr[HDR_YOVF]);
        n_pos_x = axis_clamp($signed({2'b00, r_pos_x}) + w_dx, i_width);
        // screen Y grows downward
        n_pos_y = axis_clamp($signed({2'b00, r_pos_y}) - w_dy, i_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx     <= n_pos_x;
            r_cy     <= n_pos_y;
            r_left   <= i_pkt.hdr[HDR_LEFT];
            r_middle <= i_pkt.hdr[HDR_MIDDLE];
            r_right  <= i_pkt.hdr[HDR_RIGHT];
        end
    end

    assign o_valid    = r_valid;
    assign o_cursor_x = r_cx;
    assign o_cursor_y = r_cy;
    assign o_left     = r_left;
    assign o_middle   = r_middle;
    assign o_right    = r_right;

endmodule

// ===== dv/ps2_mouse_packet_cursor_tracker_core_checker.sv =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker checker
// Watches the byte, result and register channels. Frames incoming bytes into
// packets, tracks the clamped cursor, and compares each result word field by
// field against the oldest predicted cursor word.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core_checker
    import ps2mct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [SIZE_W-1:0] i_cursor_x,
    input  logic [SIZE_W-1:0] i_cursor_y,
    input  logic              i_left_pressed,
    input  logic              i_middle_pressed,
    input  logic              i_right_pressed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                o_fail_count,
    output int                o_backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SIZE_W-1:0] x;
        logic [SIZE_W-1:0] y;
        logic              left;
        logic              middle;
        logic              right;
    } t_cursor_word;

    t_cursor_word      cursor_q[$];
    t_cursor_word      oldest;
    t_phase            framing;
    logic [7:0]        held_hdr;
    logic [7:0]        held_x;
    logic [SIZE_W-1:0] cur_x;
    logic [SIZE_W-1:0] cur_y;
    logic [SIZE_W-1:0] scr_w;
    logic [SIZE_W-1:0] scr_h;

    // signed movement: two's complement magnitude when negative, overflow adds 255
    function automatic int axis_move(input logic [7:0] b, input logic neg, input logic ovf);
        logic [7:0] m8;
        int         mag;
        m8  = neg ? 8'(8'd0 - b) : b;
        mag = int'({24'd0, m8});
        if (ovf) begin
            mag = mag + 255;
        end
        return neg ? -mag : mag;
    endfunction

    // floor at 1 first, then cap at size-1 (size zero caps at zero)
    function automatic logic [SIZE_W-1:0] fit_axis(input int v, input logic [SIZE_W-1:0] size);
        int top_lim;
        top_lim = (size == '0) ? 0 : int'({16'd0, size}) - 1;
        if (v <= 1) begin
            v = 1;
        end
        if (v >= top_lim) begin
            v = top_lim;
        end
        return v[SIZE_W-1:0];
    endfunction

    task automatic take_byte(input logic [7:0] b);
        t_cursor_word w;
        case (framing)
            PH_X: begin
                held_x  = b;
                framing = PH_Y;
            end
            PH_Y: begin
                framing = PH_HDR;
                cur_x = fit_axis(int'({16'd0, cur_x})
                                 + axis_move(held_x, held_hdr[HDR_XSIGN], held_hdr[HDR_XOVF]),
                                 scr_w);
                // screen y grows downward
                cur_y = fit_axis(int'({16'd0, cur_y})
                                 - axis_move(b, held_hdr[HDR_YSIGN], held_hdr[HDR_YOVF]),
                                 scr_h);
                w.x      = cur_x;
                w.y      = cur_y;
                w.left   = held_hdr[HDR_LEFT];
                w.middle = held_hdr[HDR_MIDDLE];
                w.right  = held_hdr[HDR_RIGHT];
                cursor_q.push_back(w);
            end
            default: begin
                // drop a header without the sync bit
                if (b[HDR_SYNC]) begin
                    held_hdr = b;
                    framing  = PH_X;
                end else begin
                    framing = PH_HDR;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            framing      = PH_HDR;
            held_hdr     = '0;
            held_x       = '0;
            cur_x        = '0;
            cur_y        = '0;
            scr_w        = WIDTH_RESET;
            scr_h        = HEIGHT_RESET;
            o_fail_count = 0;
            cursor_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[2]))
                    REG_WIDTH:  scr_w = pwdata[SIZE_W-1:0];
                    REG_HEIGHT: scr_h = pwdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (cursor_q.size() == 0) begin
                    $display("%0t: unexpected cursor word, expected none, actual x=%0d y=%0d",
                             $time, i_cursor_x, i_cursor_y);
                    o_fail_count++;
                end else begin
                    oldest = cursor_q.pop_front();
                    check_field("cursor_x", int'(oldest.x), int'(i_cursor_x));
                    check_field("cursor_y", int'(oldest.y), int'(i_cursor_y));
                    check_field("left_pressed", int'(oldest.left), int'(i_left_pressed));
                    check_field("middle_pressed", int'(oldest.middle),
                                int'(i_middle_pressed));
                    check_field("right_pressed", int'(oldest.right), int'(i_right_pressed));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_byte(i_data_byte);
            end
        end
        o_backlog = cursor_q.size();
    end

endmodule

// ===== dv/ps2_mouse_packet_cursor_tracker_core_test.sv =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker testbench
// Drives mouse bytes in bursts under random output stalls, walks the screen
// size through several settings, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core_test;
    import ps2mct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [7:0]        i_data_byte;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [SIZE_W-1:0] o_cursor_x;
    logic [SIZE_W-1:0] o_cursor_y;
    logic              o_left_pressed;
    logic              o_middle_pressed;
    logic              o_right_pressed;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int backlog;

    t_phase            frame_pos;
    int                burst_left;
    int                hold_ask;
    int                hold_seen;
    int                hold_cnt;
    int                stall_mode;
    int                mode_cnt;
    int                drain_guard;
    logic [SIZE_W-1:0] new_w;
    logic [SIZE_W-1:0] new_h;

    logic [7:0] opening_bytes[26] = '{
        8'h00, 8'hF7,             // headers without sync bit
        8'h08, 8'h00, 8'h00,      // no motion, clamps to 1,1
        8'h0F, 8'h7F, 8'h80,      // all buttons, largest plain deltas
        8'h48, 8'hFF, 8'h00,      // x overflow
        8'h48, 8'hFF, 8'h00,
        8'hA8, 8'hFF, 8'h01,      // y negative with overflow
        8'hF8, 8'h01, 8'h01,      // every sign and overflow bit
        8'h1C, 8'h00, 8'h00,      // negative zero delta
        8'h38, 8'h80, 8'h80       // both negative, half range
    };

    ps2_mouse_packet_cursor_tracker_core dut (.*);

    ps2_mouse_packet_cursor_tracker_core_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_cursor_x      (o_cursor_x),
        .i_cursor_y      (o_cursor_y),
        .i_left_pressed  (o_left_pressed),
        .i_middle_pressed(o_middle_pressed),
        .i_right_pressed (o_right_pressed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_fail_count    (fail_count),
        .o_backlog       (backlog)
    );

    always #2 i_clk = ~i_clk;

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_cnt  = 200;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_cnt == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_cnt   = $urandom_range(20, 200);
            end else begin
                mode_cnt--;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        int r;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (frame_pos)
            PH_X:    frame_pos = PH_Y;
            PH_Y:    frame_pos = PH_HDR;
            default: frame_pos = b[HDR_SYNC] ? PH_X : PH_HDR;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            r   = $urandom_range(0, 9);
            gap = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(10, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [SIZE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return the bus to idle before the next transfer
        @(posedge i_clk);
    endtask

    // wait for every predicted word, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        drain_guard = 0;
        @(negedge i_clk);
        while (backlog != 0 && drain_guard < 20000) begin
            drain_guard++;
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        frame_pos   = PH_HDR;
        burst_left  = 1;
        hold_ask    = 0;
        hold_seen   = 0;
        hold_cnt    = 0;
        stall_mode  = 0;
        mode_cnt    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
        settle();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin new_w = 16'd3;     new_h = 16'd3;     end
                1: begin new_w = 16'd65535; new_h = 16'd65535; end
                2: begin new_w = WIDTH_RESET; new_h = HEIGHT_RESET; end
                3: begin new_w = 16'd65535; new_h = 16'd3;     end
                4: begin new_w = 16'd3;     new_h = 16'd65535; end
                default: begin
                    new_w = $urandom_range(0, 1) ? 16'($urandom_range(3, 40))
                                                 : 16'($urandom_range(3, 65535));
                    new_h = $urandom_range(0, 1) ? 16'($urandom_range(3, 40))
                                                 : 16'($urandom_range(3, 65535));
                end
            endcase
            write_reg(REG_WIDTH, new_w);
            write_reg(REG_HEIGHT, new_h);
            for (int n = 0; n < 85; n++) begin
                if ((ph == 2 && n == 30) || (ph == 6 && n == 50)) begin
                    hold_ask <= hold_ask + 1;
                end
                if ($urandom_range(0, 9) < 8) begin
                    push_byte(8'($urandom) | (8'd1 << HDR_SYNC));
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                end else begin
                    // noise: may drop or knock the framing off
                    push_byte(8'($urandom));
                end
            end
            // close any open packet before touching the registers
            while (frame_pos != PH_HDR) push_byte(8'($urandom));
            settle();
        end

        if (fail_count == 0 && backlog == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ps2mct_pkg.sv
sv/ps2mct_front.sv
sv/ps2mct_fifo.sv
sv/ps2mct_back.sv
sv/ps2_mouse_packet_cursor_tracker_core.sv
dv/ps2_mouse_packet_cursor_tracker_core_checker.sv
dv/ps2_mouse_packet_cursor_tracker_core_test.sv
